// ===== rtl/gww_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gww_pkg
// shared types, constants and helpers of the greedy word wrap block
// ----------------------------------------------------------------------------
package gww_pkg;

    localparam int MAX_WIDTH   = 62;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int WIDTH_W     = 6;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_SP = 8'd32;

    localparam logic REG_LINE_WIDTH = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_EMIT_RD,
        S_EMIT_PUT,
        S_LF,
        S_MOVE_RD,
        S_MOVE_WR,
        S_ERR
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gww_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gww_store
// line buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module gww_store (
    input  wire logic              i_clk,
    input  wire gww_pkg::t_mem_req i_req,
    output logic [7:0]             o_rd_data
);
    import gww_pkg::*;

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/gww_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gww_seq
// sequencer: stores bytes, trims, emits lines and shifts the held word
// ----------------------------------------------------------------------------
module gww_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [gww_pkg::WIDTH_W-1:0]   i_line_width,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_text_byte,
    input  wire logic                          i_end_of_input,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [7:0]                         o_out_byte,
    output logic                               o_out_last,
    output logic                               o_out_err,
    output gww_pkg::t_mem_req                   o_mem_req,
    input  wire logic [7:0]                    i_rd_data
);
    import gww_pkg::*;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_word, n_word;
    logic [LEN_W-1:0]  r_keep, n_keep;
    logic [LEN_W-1:0]  r_src, n_src;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [7:0]        r_prev, n_prev;
    logic              r_halted, n_halted;
    logic              r_flush, n_flush;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_err;

    logic              out_free;
    logic              out_load;
    logic [7:0]        out_byte;
    logic              out_last;
    logic              out_err;

    logic [7:0]        v_char;
    logic              v_brk;
    logic [LEN_W-1:0]  v_len;
    logic [LEN_W-1:0]  v_word;
    logic [LEN_W-1:0]  v_width;
    logic [LEN_W-1:0]  v_idx_inc;
    logic [LEN_W-1:0]  v_src_addr;
    logic [LEN_W-1:0]  v_keep_dec;

    assign out_free   = !r_out_valid || i_out_ready;
    assign v_width    = LEN_W'(i_line_width);
    assign v_idx_inc  = r_idx + LEN_W'(1);
    assign v_src_addr = r_src + r_idx;
    assign v_keep_dec = r_keep - LEN_W'(1);
    assign v_brk      = (i_text_byte == CH_LF) && (r_prev == CH_LF);
    assign v_char     = ((i_text_byte == CH_LF) && !v_brk) ? CH_SP : i_text_byte;
    assign v_len      = r_len + LEN_W'(1);
    assign v_word     = is_ws(v_char) ? '0 : (r_word + LEN_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_word   <= '0;
            r_prev   <= '0;
            r_halted <= 1'b0;
            r_flush  <= 1'b0;
            r_keep   <= '0;
            r_src    <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_word   <= n_word;
            r_prev   <= n_prev;
            r_halted <= n_halted;
            r_flush  <= n_flush;
            r_keep   <= n_keep;
            r_src    <= n_src;
            r_idx    <= n_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_word    = r_word;
        n_prev    = r_prev;
        n_halted  = r_halted;
        n_flush   = r_flush;
        n_keep    = r_keep;
        n_src     = r_src;
        n_idx     = r_idx;
        out_load  = 1'b0;
        out_byte  = i_rd_data;
        out_last  = 1'b0;
        out_err   = 1'b0;
        o_in_ready = (r_state == S_IDLE);
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_len[ADDR_W-1:0];
        o_mem_req.wdata = v_char;
        o_mem_req.raddr = r_idx[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_halted) begin
                    if (i_end_of_input) begin
                        if (r_len != '0) begin
                            n_keep  = r_len;
                            n_idx   = '0;
                            n_flush = 1'b1;
                            n_state = S_EMIT_RD;
                        end
                        n_len  = '0;
                        n_word = '0;
                        n_prev = '0;
                    end else begin
                        n_prev = i_text_byte;
                        if (i_text_byte != CH_CR) begin
                            o_mem_req.we = 1'b1;
                            if (v_word > v_width) begin
                                n_halted = 1'b1;
                                n_len    = '0;
                                n_word   = '0;
                                n_state  = S_ERR;
                            end else if (v_brk || (v_len > v_width)) begin
                                n_keep  = v_len - v_word;
                                n_src   = v_len - v_word;
                                n_len   = v_word;
                                n_word  = v_word;
                                n_flush = 1'b0;
                                n_state = S_TRIM_RD;
                            end else begin
                                n_len  = v_len;
                                n_word = v_word;
                            end
                        end
                    end
                end
            end
            S_TRIM_RD: begin
                o_mem_req.raddr = v_keep_dec[ADDR_W-1:0];
                n_idx = '0;
                if (r_keep == '0) begin
                    n_state = S_LF;
                end else begin
                    n_state = S_TRIM_CHK;
                end
            end
            S_TRIM_CHK: begin
                o_mem_req.raddr = v_keep_dec[ADDR_W-1:0];
                if (is_ws(i_rd_data) && (i_rd_data != CH_LF)) begin
                    n_keep  = v_keep_dec;
                    n_state = S_TRIM_RD;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_PUT;
            end
            S_EMIT_PUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_idx    = v_idx_inc;
                    n_state  = (v_idx_inc == r_keep) ? S_LF : S_EMIT_RD;
                end
            end
            S_LF: begin
                out_byte = CH_LF;
                out_last = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    n_idx    = '0;
                    if (!r_flush && (r_word != '0)) begin
                        n_state = S_MOVE_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MOVE_RD: begin
                o_mem_req.raddr = v_src_addr[ADDR_W-1:0];
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_mem_req.raddr = v_src_addr[ADDR_W-1:0];
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_idx[ADDR_W-1:0];
                o_mem_req.wdata = i_rd_data;
                n_idx   = v_idx_inc;
                n_state = (v_idx_inc == r_word) ? S_IDLE : S_MOVE_RD;
            end
            S_ERR: begin
                out_byte = '0;
                out_err  = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= out_byte;
            r_out_last <= out_last;
            r_out_err  <= out_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_err   = r_out_err;

endmodule
`default_nettype wire

// ===== rtl/greedy_word_wrap.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_word_wrap
// re-flows a byte stream into lines of at most line_width characters
// ----------------------------------------------------------------------------
// One text byte is taken per item on the slave side. An ordinary byte, a
// dropped carriage return or an item while halted is taken in the idle state
// and the block is ready again at once. When a line wraps or is flushed, the
// block stays busy: on a wrap it trims, reading back each trimmed blank and
// the byte that stops it (a read, then a check) down to the line start; it
// emits each kept byte (a line-buffer read, then the output register), then
// the closing line feed, and on a wrap copies the held word to the line start
// (a read, then a write per byte). A flush skips the trim and the copy. These
// steps come from the single read port of the 64-byte line buffer, whose read
// data is registered. An over-long word gives one item with tuser set and
// halts the block until reset. The output side has a register of its own, so
// results wait there without blocking idle items.
// ----------------------------------------------------------------------------
module greedy_word_wrap (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,
    output logic [0:0]       m_axis_tuser,   // [0] word_too_long
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import gww_pkg::*;

    logic [WIDTH_W-1:0] r_line_width;
    logic [WIDTH_W-1:0] n_line_width;
    logic [WIDTH_W-1:0] cfg_raw;
    logic               cfg_wr;
    t_mem_req           mem_req;
    logic [7:0]         rd_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_LINE_WIDTH);
    assign cfg_raw = pwdata[WIDTH_W-1:0];

    always_comb begin
        if (cfg_raw == '0) begin
            n_line_width = WIDTH_W'(1);
        end else if (cfg_raw > WIDTH_W'(MAX_WIDTH)) begin
            n_line_width = WIDTH_W'(MAX_WIDTH);
        end else begin
            n_line_width = cfg_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= WIDTH_W'(MAX_WIDTH);
        end else if (cfg_wr) begin
            r_line_width <= n_line_width;
        end
    end

    assign prdata = (paddr[2] == REG_LINE_WIDTH) ? 32'(r_line_width) : '0;

    gww_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_line_width   (r_line_width),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_text_byte    (s_axis_tdata),
        .i_end_of_input (s_axis_tuser[0]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_byte     (m_axis_tdata),
        .o_out_last     (m_axis_tlast),
        .o_out_err      (m_axis_tuser[0]),
        .o_mem_req      (mem_req),
        .i_rd_data      (rd_data)
    );

    gww_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // a line end is always a line feed
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata == CH_LF))
        else $error("line end item is not a line feed");

    // the error item is never a line end
    a_err_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast)
        else $error("error item marked as line end");

    // nothing follows the error item
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[0] |=> !m_axis_tvalid)
        else $error("item emitted after word too long");

endmodule
`default_nettype wire

// ===== dv/greedy_word_wrap_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_tb
// self-checking bench for the greedy word wrap block
// ----------------------------------------------------------------------------
// A queue of text items feeds a bursty stream driver. Every item the block
// accepts is run through a wrap predictor in the bench, and its output bytes
// are queued. The monitor checks each output item against that queue while
// the receiver stalls on a changing pattern. Line width goes through several
// values, including the extremes and a lowering in the middle of a line. The
// run ends with an over-long word that halts the block.
// ----------------------------------------------------------------------------
module greedy_word_wrap_tb;
    import gww_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int SETTLE       = 200;
    localparam int LIMIT_CYCLES = 2_500_000;
    localparam int PRINT_CAP    = 40;
    localparam int PHASE_ITEMS  = 50;
    localparam logic SPARE_REG  = 1'b1;

    typedef struct packed {
        logic       eoi;
        logic [7:0] ch;
    } t_text_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } t_wrap_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] text_byte
    logic [0:0]  s_axis_tuser = '0;   // [0] end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] out_byte
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;        // [0] word_too_long
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    greedy_word_wrap DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    t_text_item text_q[$];
    t_wrap_out  wrapped_q[$];

    // wrap predictor state
    logic [7:0] line_buf [0:STORE_DEPTH-1];
    int         line_len = 0;
    int         word_len = 0;
    logic [7:0] prev_raw = '0;
    bit         halted = 1'b0;
    int         wrap_width = MAX_WIDTH;

    int  mismatches = 0;
    int  items_in = 0;
    int  bytes_out = 0;
    int  lines_out = 0;
    int  widths_used = 1;
    bit  halt_seen = 1'b0;
    int  cycles = 0;
    bit  taken = 1'b0;

    // text generator state
    int  gen_width = MAX_WIDTH;
    int  gen_run = 0;

    function automatic bit is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic int clamp_width(input logic [31:0] value);
        int v;
        v = int'(value[WIDTH_W-1:0]);
        if (v < 1)
            v = 1;
        if (v > MAX_WIDTH)
            v = MAX_WIDTH;
        return v;
    endfunction

    function automatic void emit(input logic [7:0] ch, input logic last, input logic err);
        wrapped_q.push_back('{ch: ch, last: last, err: err});
    endfunction

    function automatic void wrap_text(input logic [7:0] raw, input logic eoi);
        logic [7:0] prev;
        logic [7:0] c;
        bit         brk;
        int         keep;
        brk = 1'b0;
        if (halted)
            return;
        if (eoi) begin
            if (line_len > 0) begin
                for (int i = 0; i < line_len; i++)
                    emit(line_buf[i], 1'b0, 1'b0);
                emit(CH_LF, 1'b1, 1'b0);
            end
            line_len = 0;
            word_len = 0;
            prev_raw = '0;
            return;
        end
        prev = prev_raw;
        prev_raw = raw;
        if (raw == CH_CR)
            return;
        c = raw;
        if (c == CH_LF) begin
            if (prev == CH_LF)
                brk = 1'b1;
            else
                c = CH_SP;
        end
        if (line_len < STORE_DEPTH) begin
            line_buf[line_len] = c;
            line_len++;
        end
        if (is_blank(c))
            word_len = 0;
        else if (word_len < STORE_DEPTH)
            word_len++;
        if (word_len > wrap_width) begin
            emit(8'd0, 1'b0, 1'b1);
            halted = 1'b1;
            line_len = 0;
            word_len = 0;
            return;
        end
        if (brk || line_len > wrap_width) begin
            keep = line_len - word_len;
            while (keep > 0 && is_blank(line_buf[keep-1]) && line_buf[keep-1] != CH_LF)
                keep--;
            for (int i = 0; i < keep; i++)
                emit(line_buf[i], 1'b0, 1'b0);
            emit(CH_LF, 1'b1, 1'b0);
            for (int i = 0; i < word_len; i++)
                line_buf[i] = line_buf[line_len - word_len + i];
            line_len = word_len;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] output item %0d: %s", $time, bytes_out, msg);
        mismatches++;
    endtask

    // stimulus helpers
    function automatic void push_item(input logic [7:0] ch, input logic eoi);
        text_q.push_back('{eoi: eoi, ch: ch});
    endfunction

    // keeps every word within the current width so the block never halts early
    function automatic void push_text(input logic [7:0] b);
        if (!is_blank(b) && gen_run >= gen_width) begin
            push_item(CH_SP, 1'b0);
            gen_run = 0;
        end
        push_item(b, 1'b0);
        if (b != CH_CR) begin
            if (is_blank(b))
                gen_run = 0;
            else
                gen_run++;
        end
    endfunction

    function automatic void push_eoi();
        push_item(8'($urandom_range(0, 255)), 1'b1);
        gen_run = 0;
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_blank(b));
        return b;
    endfunction

    function automatic void gen_phase(input int n);
        int start;
        int len;
        int sel;
        start = text_q.size();
        gen_run = 0;
        while (text_q.size() - start < n) begin
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, gen_width);
            else
                len = $urandom_range(1, gen_width < 8 ? gen_width : 8);
            repeat (len) push_text(word_char());
            if ($urandom_range(0, 99) < 4)
                push_text(8'($urandom_range(0, 255)));
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                push_text(CH_SP);
            end else if (sel < 60) begin
                repeat ($urandom_range(2, 4)) push_text(CH_SP);
            end else if (sel < 70) begin
                push_text(CH_LF);
            end else if (sel < 78) begin
                push_text(CH_LF);
                push_text(CH_LF);
            end else if (sel < 84) begin
                push_text(CH_CR);
                push_text(CH_LF);
            end else if (sel < 88) begin
                push_text(CH_CR);
                push_text(CH_SP);
            end else if (sel < 92) begin
                push_text(8'd9);
            end else if (sel < 96) begin
                push_text($urandom_range(0, 1) ? 8'd11 : 8'd12);
            end else begin
                repeat (3) push_text(CH_LF);
            end
            if ($urandom_range(0, 99) < 3)
                push_eoi();
        end
        push_eoi();
    endfunction

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (text_q.size() != 0 || s_axis_tvalid || wrapped_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [31:0] data);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (reg_idx == REG_LINE_WIDTH) begin
            wrap_width = clamp_width(data);
            gen_width = wrap_width;
            widths_used++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stream driver
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge i_clk) begin : feed
        t_text_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (text_q.size() > 0) begin
                nxt = text_q.pop_front();
                s_axis_tdata  <= nxt.ch;
                s_axis_tuser  <= nxt.eoi;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int rx_mode = 0;
    int rx_left = 0;
    int rx_tick = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 200);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_tick % 7) < 4;
        endcase
    end

    // acceptance, prediction and output check
    always @(posedge i_clk) begin : watch
        t_wrap_out want;
        if (!i_rst_n) begin
            taken <= 1'b0;
        end else begin
            taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                wrap_text(s_axis_tdata, s_axis_tuser[0]);
                items_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (wrapped_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item byte=%02h last=%0b err=%0b",
                                              m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
                end else begin
                    want = wrapped_q.pop_front();
                    if (m_axis_tdata !== want.ch)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  m_axis_tdata, want.ch));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last_of_line %0b, want %0b",
                                                  m_axis_tlast, want.last));
                    if (m_axis_tuser[0] !== want.err)
                        report_mismatch($sformatf("word_too_long %0b, want %0b",
                                                  m_axis_tuser[0], want.err));
                    if (want.last)
                        lines_out++;
                    if (want.err)
                        halt_seen = 1'b1;
                end
                bytes_out++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("run stopped at cycle limit, %0d output items pending", wrapped_q.size());
            $display("greedy_word_wrap: mismatch");
            $finish;
        end
    end

    initial begin
        logic [31:0] phase_widths [7];
        phase_widths = '{32'h0000_003F, 32'hFFFF_FF47, 32'd20,
                         32'($urandom_range(2, 61)), 32'd1, 32'd40, 32'd3};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty flush, dropped return, single and double line feeds, byte extremes
        push_item(8'h00, 1'b1);
        push_item("a", 1'b0);
        push_item(CH_CR, 1'b0);
        push_item(CH_LF, 1'b0);
        push_item("b", 1'b0);
        push_item(CH_LF, 1'b0);
        push_item(CH_LF, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'd9, 1'b0);
        push_item(8'hFF, 1'b1);

        // narrow width: trim back to line start, then a held word
        apb_write(REG_LINE_WIDTH, 32'd3);
        repeat (4) push_item(CH_SP, 1'b0);
        push_item("a", 1'b0);
        push_item("b", 1'b0);
        push_item(CH_SP, 1'b0);
        push_item("c", 1'b0);
        push_item("d", 1'b0);
        push_item(8'h00, 1'b1);
        push_item("e", 1'b0);
        push_item(CH_SP, 1'b0);

        // width lowered with a line pending, zero taken as one
        apb_write(REG_LINE_WIDTH, 32'd0);
        push_item("g", 1'b0);
        push_item(8'h55, 1'b1);

        apb_write(SPARE_REG, 32'd5);

        foreach (phase_widths[p]) begin
            apb_write(REG_LINE_WIDTH, phase_widths[p]);
            gen_phase(PHASE_ITEMS);
        end

        // over-long word after a mid-line lowering halts the block
        apb_write(REG_LINE_WIDTH, 32'd10);
        push_item("x", 1'b0);
        push_item("y", 1'b0);
        push_item(CH_SP, 1'b0);
        push_item("a", 1'b0);
        push_item("b", 1'b0);
        push_item("c", 1'b0);
        push_item("d", 1'b0);
        push_item("e", 1'b0);
        push_item("f", 1'b0);
        apb_write(REG_LINE_WIDTH, 32'd4);
        push_item("g", 1'b0);
        push_item("h", 1'b0);
        push_item(8'h00, 1'b1);
        push_item(CH_LF, 1'b0);
        wait_idle();

        $display("%0d text items in, %0d output items in %0d lines, %0d width settings",
                 items_in, bytes_out, lines_out, widths_used);
        $display("halt on over-long word %s", halt_seen ? "seen" : "not seen");
        if (mismatches == 0 && wrapped_q.size() == 0 && halt_seen)
            $display("greedy_word_wrap: match");
        else
            $display("greedy_word_wrap: mismatch");
        $finish;
    end

endmodule
